// File: rtl/core/size_weighted_lru_store_assert.svh
// assertion macros shared by the checker of the keyed lru store
// depends on nothing; expects clk and rst_n in the scope of use
`ifndef SIZE_WEIGHTED_LRU_STORE_ASSERT_SVH
`define SIZE_WEIGHTED_LRU_STORE_ASSERT_SVH

// same-cycle implication
`define SLRU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slru same-cycle check failed");

// next-cycle implication
`define SLRU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slru next-cycle check failed");

`endif

// File: rtl/core/slru_pkg.sv
// shared types and defaults of the keyed lru store
// no dependencies
package slru_pkg;

    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int SIZE_W  = 16;
    localparam int CAP_W   = 24;
    localparam int EVC_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 24'd65536;

    typedef enum logic [2:0] {
        OP_PUT    = 3'd0,
        OP_GET    = 3'd1,
        OP_HAS    = 3'd2,
        OP_QUERY  = 3'd3,
        OP_REMOVE = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UL_RD,
        ST_UL_GO,
        ST_SN_RD,
        ST_SN_WR,
        ST_SP_RD,
        ST_SP_WR,
        ST_CHK,
        ST_HD_RD,
        ST_EVICT,
        ST_APPEND,
        ST_DONE
    } state_t;

endpackage

// File: rtl/core/slru_ram.sv
// generic single-write, single-read synchronous ram with registered read
// depends on slru_pkg for its defaults
module slru_ram import slru_pkg::*;
#(
    parameter int WIDTH = DEF_KEY_BITS,
    parameter int DEPTH = DEF_ENTRIES
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/size_weighted_lru_store.sv
// keyed store with recency order and a size-weighted capacity limit
// depends on slru_pkg and slru_ram
// each command scans every entry; put, remove and a get not at the tail unlink a hit;
// a put evicts the head while full or over capacity; put and a get hit then append
// one item at a time: the key scan reads the data ram one entry a cycle
// reset: empty store, used total zero, capacity 65536; the receiver cannot stall
module size_weighted_lru_store import slru_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         op,
    input  logic [KEY_W-1:0]   key,
    input  logic [VALUE_W-1:0] value,
    input  logic [SIZE_W-1:0]  item_size,
    output logic               done,
    output logic               hit,
    output logic [VALUE_W-1:0] found_value,
    output logic [SIZE_W-1:0]  found_size,
    output logic [EVC_W-1:0]   evicted_count,
    output logic [CAP_W-1:0]   used_total,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CAP_W-1:0]   cfg_data
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int SW = IW + 1;
    localparam int DW = KEY_BITS + VALUE_BITS + SIZE_W;
    localparam int LW = 2 * IW;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [CAP_W-1:0]      cap_reg, cap_next;
    logic [CAP_W-1:0]      sum_reg, sum_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [IW-1:0]         head_reg, head_next;
    logic [IW-1:0]         tail_reg, tail_next;
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [SW-1:0]         scan_reg, scan_next;
    logic                  hit_reg, hit_next;
    logic [IW-1:0]         slot_reg, slot_next;
    logic [IW-1:0]         free_reg, free_next;
    logic                  free_ok_reg, free_ok_next;
    logic [VALUE_BITS-1:0] fval_reg, fval_next;
    logic [SIZE_W-1:0]     fsize_reg, fsize_next;
    logic [SIZE_W-1:0]     ssize_reg, ssize_next;
    logic [CW-1:0]         ev_reg, ev_next;
    logic [IW-1:0]         a_reg, a_next;
    logic [IW-1:0]         v_reg, v_next;
    logic [IW-1:0]         p_reg, p_next;
    logic [IW-1:0]         n_reg, n_next;
    logic                  ul_reg, ul_next;

    logic          d_we;
    logic [IW-1:0] d_waddr, d_raddr;
    logic [DW-1:0] d_wdata, d_rdata;
    logic          l_we;
    logic [IW-1:0] l_waddr, l_raddr;
    logic [LW-1:0] l_wdata, l_rdata;

    logic [KEY_BITS-1:0]   d_key;
    logic [VALUE_BITS-1:0] d_val;
    logic [SIZE_W-1:0]     d_size;
    logic [IW-1:0]         l_prev, l_next;
    logic [IW-1:0]         scan_idx;
    logic [IW-1:0]         tgt;
    state_t                after_ul;
    logic                  over;

    slru_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_data_ram
    (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    // recency list: prev and next slot of every entry
    slru_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_link_ram
    (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    assign d_key    = d_rdata[DW-1 -: KEY_BITS];
    assign d_val    = d_rdata[SIZE_W +: VALUE_BITS];
    assign d_size   = d_rdata[SIZE_W-1:0];
    assign l_prev   = l_rdata[LW-1 -: IW];
    assign l_next   = l_rdata[IW-1:0];
    assign scan_idx = IW'(scan_reg - SW'(1));
    assign tgt      = (op_reg == OP_GET) ? slot_reg : free_reg;
    assign over     = ({1'b0, sum_reg} + (CAP_W + 1)'(size_reg)) > {1'b0, cap_reg};

    always_comb
    begin
        case (op_reg)
            OP_GET:  after_ul = ST_APPEND;
            OP_PUT:  after_ul = ST_CHK;
            default: after_ul = ST_DONE;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        size_next    = size_reg;
        cap_next     = cap_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        valid_next   = valid_reg;
        scan_next    = scan_reg;
        hit_next     = hit_reg;
        slot_next    = slot_reg;
        free_next    = free_reg;
        free_ok_next = free_ok_reg;
        fval_next    = fval_reg;
        fsize_next   = fsize_reg;
        ssize_next   = ssize_reg;
        ev_next      = ev_reg;
        a_next       = a_reg;
        v_next       = v_reg;
        p_next       = p_reg;
        n_next       = n_reg;
        ul_next      = ul_reg;
        d_we         = 1'b0;
        d_waddr      = tgt;
        d_wdata      = {key_reg, val_reg, size_reg};
        d_raddr      = head_reg;
        l_we         = 1'b0;
        l_waddr      = tgt;
        l_wdata      = {tail_reg, IW'(0)};
        l_raddr      = head_reg;

        if (cfg_valid && cfg_ready)
        begin
            cap_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next      = op_t'(op);
                    key_next     = KEY_BITS'(key);
                    val_next     = VALUE_BITS'(value);
                    size_next    = item_size;
                    hit_next     = 1'b0;
                    free_ok_next = 1'b0;
                    fval_next    = '0;
                    fsize_next   = '0;
                    ev_next      = '0;
                    ul_next      = 1'b0;
                    scan_next    = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                d_raddr = scan_reg[IW-1:0];
                // data of the previous address is on the read port now
                if (scan_reg != SW'(0))
                begin
                    if (valid_reg[scan_idx] && d_key == key_reg)
                    begin
                        hit_next   = 1'b1;
                        slot_next  = scan_idx;
                        fval_next  = d_val;
                        fsize_next = d_size;
                        ssize_next = d_size;
                    end
                    if (!valid_reg[scan_idx] && !free_ok_reg)
                    begin
                        free_next    = scan_idx;
                        free_ok_next = 1'b1;
                    end
                end
                if (scan_reg == SW'(ENTRIES))
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    scan_next = scan_reg + SW'(1);
                end
            end
            ST_DECIDE:
            begin
                if (op_reg != OP_GET)
                begin
                    fval_next = '0;
                end
                if (op_reg != OP_QUERY)
                begin
                    fsize_next = '0;
                end
                case (op_reg)
                    OP_PUT:    state_next = hit_reg ? ST_UL_RD : ST_CHK;
                    OP_GET:    state_next = (hit_reg && slot_reg != tail_reg) ? ST_UL_RD
                                                                              : ST_DONE;
                    OP_REMOVE: state_next = hit_reg ? ST_UL_RD : ST_DONE;
                    OP_CLEAR:
                    begin
                        ev_next    = count_reg;
                        valid_next = '0;
                        count_next = '0;
                        sum_next   = '0;
                        state_next = ST_DONE;
                    end
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_UL_RD:
            begin
                l_raddr    = slot_reg;
                state_next = ST_UL_GO;
            end
            ST_UL_GO:
            begin
                p_next = l_prev;
                n_next = l_next;
                if (op_reg != OP_GET)
                begin
                    valid_next[slot_reg] = 1'b0;
                    count_next           = count_reg - CW'(1);
                    sum_next             = sum_reg - CAP_W'(ssize_reg);
                    ev_next              = ev_reg + CW'(1);
                    free_next            = slot_reg;
                end
                if (slot_reg == head_reg && slot_reg == tail_reg)
                begin
                    state_next = after_ul;
                end
                else if (slot_reg == head_reg)
                begin
                    head_next  = l_next;
                    state_next = after_ul;
                end
                else if (slot_reg == tail_reg)
                begin
                    tail_next  = l_prev;
                    state_next = after_ul;
                end
                else
                begin
                    a_next     = l_prev;
                    v_next     = l_next;
                    ul_next    = 1'b1;
                    state_next = ST_SN_RD;
                end
            end
            ST_SN_RD:
            begin
                l_raddr    = a_reg;
                state_next = ST_SN_WR;
            end
            ST_SN_WR:
            begin
                l_we       = 1'b1;
                l_waddr    = a_reg;
                l_wdata    = {l_prev, v_reg};
                state_next = ul_reg ? ST_SP_RD : ST_DONE;
            end
            ST_SP_RD:
            begin
                l_raddr    = n_reg;
                state_next = ST_SP_WR;
            end
            ST_SP_WR:
            begin
                l_we       = 1'b1;
                l_waddr    = n_reg;
                l_wdata    = {p_reg, l_next};
                ul_next    = 1'b0;
                state_next = after_ul;
            end
            ST_CHK:
            begin
                if (count_reg != CW'(0) && (over || count_reg == CW'(ENTRIES)))
                begin
                    state_next = ST_HD_RD;
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_HD_RD:
            begin
                d_raddr    = head_reg;
                l_raddr    = head_reg;
                state_next = ST_EVICT;
            end
            ST_EVICT:
            begin
                // oldest entry leaves; its prev link is never read again
                valid_next[head_reg] = 1'b0;
                head_next            = l_next;
                count_next           = count_reg - CW'(1);
                sum_next             = sum_reg - CAP_W'(d_size);
                ev_next              = ev_reg + CW'(1);
                free_next            = head_reg;
                state_next           = ST_CHK;
            end
            ST_APPEND:
            begin
                l_we      = 1'b1;
                tail_next = tgt;
                a_next    = tail_reg;
                v_next    = tgt;
                if (op_reg != OP_GET)
                begin
                    d_we            = 1'b1;
                    valid_next[tgt] = 1'b1;
                    count_next      = count_reg + CW'(1);
                    sum_next        = sum_reg + CAP_W'(size_reg);
                end
                if (op_reg != OP_GET && count_reg == CW'(0))
                begin
                    head_next  = tgt;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SN_RD;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_PUT;
            key_reg     <= '0;
            val_reg     <= '0;
            size_reg    <= '0;
            cap_reg     <= CAP_RESET;
            sum_reg     <= '0;
            count_reg   <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            valid_reg   <= '0;
            scan_reg    <= '0;
            hit_reg     <= 1'b0;
            slot_reg    <= '0;
            free_reg    <= '0;
            free_ok_reg <= 1'b0;
            fval_reg    <= '0;
            fsize_reg   <= '0;
            ssize_reg   <= '0;
            ev_reg      <= '0;
            a_reg       <= '0;
            v_reg       <= '0;
            p_reg       <= '0;
            n_reg       <= '0;
            ul_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            key_reg     <= key_next;
            val_reg     <= val_next;
            size_reg    <= size_next;
            cap_reg     <= cap_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            valid_reg   <= valid_next;
            scan_reg    <= scan_next;
            hit_reg     <= hit_next;
            slot_reg    <= slot_next;
            free_reg    <= free_next;
            free_ok_reg <= free_ok_next;
            fval_reg    <= fval_next;
            fsize_reg   <= fsize_next;
            ssize_reg   <= ssize_next;
            ev_reg      <= ev_next;
            a_reg       <= a_next;
            v_reg       <= v_next;
            p_reg       <= p_next;
            n_reg       <= n_next;
            ul_reg      <= ul_next;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign cfg_ready     = (state_reg == ST_IDLE);
    assign done          = (state_reg == ST_DONE);
    assign hit           = hit_reg;
    assign found_value   = VALUE_W'(fval_reg);
    assign found_size    = fsize_reg;
    assign evicted_count = (32'(ev_reg) > 32'd31) ? 5'd31 : EVC_W'(ev_reg);
    assign used_total    = sum_reg;

endmodule

// File: rtl/core/slru_checker.sv
// port-level checks of the keyed lru store, bound to the top level
// depends on slru_pkg and size_weighted_lru_store_assert.svh
`include "size_weighted_lru_store_assert.svh"

module slru_checker import slru_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic               hit,
    input logic [VALUE_W-1:0] found_value,
    input logic [SIZE_W-1:0]  found_size,
    input logic               cfg_valid,
    input logic               cfg_ready
);

    // a result beat only closes a command in flight
    `SLRU_ASSERT_NOW(a_done_busy, done, busy)
    `SLRU_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `SLRU_ASSERT_NEXT(a_done_single, done, !done)
    // data fields only on a hit
    `SLRU_ASSERT_NOW(a_miss_zero, done && !hit, found_value == '0 && found_size == '0)
    // capacity beats only land between commands
    `SLRU_ASSERT_NOW(a_cfg_idle, cfg_valid && cfg_ready, !busy)

endmodule

bind size_weighted_lru_store slru_checker u_slru_checker (.*);
